### rtl/lpg_pkg.sv
// lpg_pkg: shared constants and the cordic arctangent table for the light-bar pair geometry unit
// no dependencies
`default_nettype none
package lpg_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANG_W             = 16;
	localparam int COORD_W           = 16;
	localparam int RATIO_W           = 16;
	localparam int ERR_W             = 14;
	localparam int ROLL_W            = 18;
	localparam int CX_W              = 28;
	localparam int CZ_W              = 36;

	localparam logic [14:0] ANG_HALF_PI = 15'd12868;
	localparam logic [14:0] ANG_PI      = 15'd25736;
	localparam logic signed [CZ_W-1:0] Z_PI = 36'sd3373259426;
	localparam logic [RATIO_W-1:0] SAT16 = 16'hFFFF;

	// atan(2^-i) in units of 2^-30 rad
	function automatic logic signed [CZ_W-1:0] cordic_atan(input int i);
		logic signed [CZ_W-1:0] v;
		case (i)
			0:  v = 36'sd843314857;
			1:  v = 36'sd497837829;
			2:  v = 36'sd263043837;
			3:  v = 36'sd133525159;
			4:  v = 36'sd67021687;
			5:  v = 36'sd33543516;
			6:  v = 36'sd16775851;
			7:  v = 36'sd8388437;
			8:  v = 36'sd4194283;
			9:  v = 36'sd2097149;
			10: v = 36'sd1048576;
			11: v = 36'sd524288;
			12: v = 36'sd262144;
			13: v = 36'sd131072;
			14: v = 36'sd65536;
			15: v = 36'sd32768;
			16: v = 36'sd16384;
			17: v = 36'sd8192;
			18: v = 36'sd4096;
			19: v = 36'sd2048;
			20: v = 36'sd1024;
			21: v = 36'sd512;
			22: v = 36'sd256;
			23: v = 36'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/lpg_delay.sv
// lpg_delay: fixed-depth shift register that keeps side data aligned with the arithmetic units
// no dependencies
`default_nettype none
module lpg_delay #(
	parameter int W     = 16,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);
	logic [W-1:0] tap_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		tap_q[0] <= din;
		for (int k = 1; k < DEPTH; k++) begin
			tap_q[k] <= tap_q[k-1];
		end
	end

	assign dout = tap_q[DEPTH-1];
endmodule
`default_nettype wire

### rtl/lpg_isqrt.sv
// lpg_isqrt: pipelined integer square root, one result bit per stage, 25 stages
// no dependencies
`default_nettype none
module lpg_isqrt (
	input  wire logic        clk,
	input  wire logic [49:0] radicand,
	output logic      [24:0] root
);
	logic [49:0] n_s    [1:24];
	logic [27:0] rem_s  [1:24];
	logic [24:0] root_s [1:25];

	for (genvar k = 0; k < 25; k++) begin : g_st
		logic [49:0] n_cur;
		logic [27:0] rem_cur, rem_new, trial;
		logic [24:0] root_cur;
		if (k == 0) begin : g_first
			assign n_cur    = radicand;
			assign rem_cur  = '0;
			assign root_cur = '0;
		end else begin : g_next
			assign n_cur    = n_s[k];
			assign rem_cur  = rem_s[k];
			assign root_cur = root_s[k];
		end
		assign rem_new = {rem_cur[25:0], n_cur[49:48]};
		assign trial   = {1'b0, root_cur, 2'b01};

		always_ff @(posedge clk) begin
			if (rem_new >= trial) begin
				root_s[k+1] <= {root_cur[23:0], 1'b1};
			end else begin
				root_s[k+1] <= {root_cur[23:0], 1'b0};
			end
		end
		if (k < 24) begin : g_rem
			always_ff @(posedge clk) begin
				n_s[k+1] <= {n_cur[47:0], 2'b00};
				if (rem_new >= trial) begin
					rem_s[k+1] <= rem_new - trial;
				end else begin
					rem_s[k+1] <= rem_new;
				end
			end
		end
	end

	assign root = root_s[25];
endmodule
`default_nettype wire

### rtl/lpg_div.sv
// lpg_div: pipelined restoring divider, 16 quotient bits, one bit per stage
// expects dividend < divisor * 2^16; saturation is handled outside
`default_nettype none
module lpg_div #(
	parameter int NW = 25
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [15:0]   divisor,
	output logic      [15:0]   quotient
);
	logic [31:0] r_s [1:15];
	logic [15:0] d_s [1:15];
	logic [15:0] q_s [1:16];

	for (genvar j = 0; j < 16; j++) begin : g_st
		localparam int B = 15 - j;
		logic [31:0] r_cur, d_sh;
		logic [15:0] d_cur, q_cur;
		if (j == 0) begin : g_first
			assign r_cur = 32'(dividend);
			assign d_cur = divisor;
			assign q_cur = '0;
		end else begin : g_next
			assign r_cur = r_s[j];
			assign d_cur = d_s[j];
			assign q_cur = q_s[j];
		end
		assign d_sh = {16'b0, d_cur} << B;

		always_ff @(posedge clk) begin
			if (r_cur >= d_sh) begin
				q_s[j+1] <= q_cur | (16'b1 << B);
			end else begin
				q_s[j+1] <= q_cur;
			end
		end
		if (j < 15) begin : g_rem
			always_ff @(posedge clk) begin
				d_s[j+1] <= d_cur;
				if (r_cur >= d_sh) begin
					r_s[j+1] <= r_cur - d_sh;
				end else begin
					r_s[j+1] <= r_cur;
				end
			end
		end
	end

	assign quotient = q_s[16];
endmodule
`default_nettype wire

### rtl/lpg_cordic.sv
// lpg_cordic: vectoring cordic giving the centre line angle, rounded to Q3.13
// depends on lpg_pkg; an input register, the iteration stages, then an output register
`default_nettype none
module lpg_cordic #(
	parameter int STAGES = lpg_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                               clk,
	input  wire logic signed [16:0]                 dx,
	input  wire logic signed [16:0]                 dy,
	output logic signed      [lpg_pkg::ROLL_W-1:0]  roll
);
	import lpg_pkg::*;

	logic signed [CX_W-1:0] x_s [0:STAGES];
	logic signed [CX_W-1:0] y_s [0:STAGES];
	logic signed [CZ_W-1:0] z_s [0:STAGES];
	logic                   zero_s [0:STAGES];
	logic signed [CX_W-1:0] x0, y0;
	logic signed [CZ_W-1:0] z_rnd;

	assign x0 = CX_W'(dx) <<< 8;
	assign y0 = CX_W'(dy) <<< 8;

	// left-pointing line: turn by pi first
	always_ff @(posedge clk) begin
		zero_s[0] <= (dx == '0) && (dy == '0);
		if (dx < 0) begin
			x_s[0] <= -x0;
			y_s[0] <= -y0;
			z_s[0] <= (dy >= 0) ? Z_PI : -Z_PI;
		end else begin
			x_s[0] <= x0;
			y_s[0] <= y0;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_it
		logic signed [CX_W-1:0] xs, ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + cordic_atan(i);
			end else begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - cordic_atan(i);
			end
		end
	end

	assign z_rnd = (z_s[STAGES] + 36'sd65536) >>> 17;

	always_ff @(posedge clk) begin
		if (zero_s[STAGES]) begin
			roll <= '0;
		end else begin
			roll <= z_rnd[ROLL_W-1:0];
		end
	end
endmodule
`default_nettype wire

### rtl/lpg_err.sv
// lpg_err: per-bar deviation from perpendicular, folded modulo pi, and the worse of the two
// depends on lpg_pkg; the mod-pi reduction and the final maximum are registered
`default_nettype none
module lpg_err (
	input  wire logic                              clk,
	input  wire logic signed [lpg_pkg::ANG_W-1:0]  left_angle,
	input  wire logic signed [lpg_pkg::ANG_W-1:0]  right_angle,
	input  wire logic signed [lpg_pkg::ROLL_W-1:0] roll,
	output logic             [lpg_pkg::ERR_W-1:0]  err
);
	import lpg_pkg::*;

	localparam logic signed [20:0] OFS = 21'sd102944 - 21'sd12868;
	localparam logic [19:0] P1 = 20'(ANG_PI);
	localparam logic [19:0] P2 = 20'(ANG_PI) << 1;
	localparam logic [19:0] P4 = 20'(ANG_PI) << 2;

	logic [14:0] rl_s1, rr_s1;

	// reduce a positive offset value (below 7 pi) modulo pi
	function automatic logic [14:0] mod_pi(input logic [19:0] v);
		logic [19:0] t;
		t = v;
		if (t >= P4) t = t - P4;
		if (t >= P2) t = t - P2;
		if (t >= P1) t = t - P1;
		return t[14:0];
	endfunction

	function automatic logic [14:0] fold(input logic [14:0] r);
		logic [14:0] c;
		c = ANG_PI - r;
		return (r <= c) ? r : c;
	endfunction

	logic signed [20:0] vl, vr;
	logic [14:0] el, er;

	assign vl = 21'(left_angle) + OFS - 21'(roll);
	assign vr = 21'(right_angle) + OFS - 21'(roll);

	always_ff @(posedge clk) begin
		rl_s1 <= mod_pi(vl[19:0]);
		rr_s1 <= mod_pi(vr[19:0]);
	end

	assign el = fold(rl_s1);
	assign er = fold(rr_s1);

	always_ff @(posedge clk) begin
		err <= (el > er) ? el[ERR_W-1:0] : er[ERR_W-1:0];
	end
endmodule
`default_nettype wire

### rtl/lightbar_pair_geometry_unit.sv
// lightbar_pair_geometry_unit: top level, midpoint, span and length ratios, squareness error
// depends on lpg_pkg, lpg_delay, lpg_isqrt, lpg_div, lpg_cordic, lpg_err
//
// channel   direction  handshake              payload
// ------    ---------  ---------------------  ---------------------------------------------
// input     in         start, busy (always 0) left/right center_x, center_y, length, angle
// result    out        done strobe            mid_x/y, span_ratio(+valid), length_ratio(+valid),
//                                             squareness_error
//
// an item is accepted every cycle that start is high; busy never rises
// each result appears on done as a strobe one cycle wide
// the pipeline depth is set by the span path: 25-stage square root then 16-stage divider
// arst_n clears only the valid chain; data registers run free
// the receiver cannot stall, so the pipeline never holds
`default_nettype none
module lightbar_pair_geometry_unit #(
	parameter int CORDIC_STAGES = lpg_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic        [lpg_pkg::COORD_W-1:0]  left_center_x,
	input  wire logic        [lpg_pkg::COORD_W-1:0]  left_center_y,
	input  wire logic        [lpg_pkg::COORD_W-1:0]  left_length,
	input  wire logic signed [lpg_pkg::ANG_W-1:0]    left_angle,
	input  wire logic        [lpg_pkg::COORD_W-1:0]  right_center_x,
	input  wire logic        [lpg_pkg::COORD_W-1:0]  right_center_y,
	input  wire logic        [lpg_pkg::COORD_W-1:0]  right_length,
	input  wire logic signed [lpg_pkg::ANG_W-1:0]    right_angle,
	output logic                                     done,
	output logic             [lpg_pkg::COORD_W-1:0]  mid_x,
	output logic             [lpg_pkg::COORD_W-1:0]  mid_y,
	output logic             [lpg_pkg::RATIO_W-1:0]  span_ratio,
	output logic                                     span_ratio_valid,
	output logic             [lpg_pkg::RATIO_W-1:0]  length_ratio,
	output logic                                     length_ratio_valid,
	output logic             [lpg_pkg::ERR_W-1:0]    squareness_error
);
	import lpg_pkg::*;

	// result data is complete at stage LAT-1, registered onto the ports at stage LAT
	localparam int LAT = 46;

	logic [LAT-1:0] vld_q;

	// stage 1: differences, longer/shorter length, midpoints
	logic signed [16:0] dx_s1, dy_s1;
	logic [15:0] maxl_s1, minl_s1, midx_s1, midy_s1;
	logic signed [ANG_W-1:0] la_s1, ra_s1;

	// stage 2 and 3: squared distance
	logic [31:0] sqx_s2, sqy_s2;
	logic [32:0] d2_s3;

	// stage 29: span saturation check ahead of the divider
	logic [24:0] root_s28, root_s29;
	logic [15:0] maxl_s28, maxl_s29;
	logic ssat_s29, snz_s29;

	logic [15:0] span_q45, len_q17, len_q45;
	logic [1:0] sflags_s45, lflags_s45;
	logic [31:0] mid_s45;
	logic signed [ROLL_W-1:0] roll_c;
	logic [2*ANG_W-1:0] ang_al;
	logic [ERR_W-1:0] err_c, err_s45;
	logic lsat_s1, lnz_s1;

	assign busy = 1'b0;

	// valid bits follow the items through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end
	assign done = vld_q[LAT-1];

	always_ff @(posedge clk) begin
		dx_s1   <= 17'(right_center_x) - 17'(left_center_x);
		dy_s1   <= 17'(right_center_y) - 17'(left_center_y);
		maxl_s1 <= (left_length > right_length) ? left_length : right_length;
		minl_s1 <= (left_length < right_length) ? left_length : right_length;
		midx_s1 <= 16'((17'(left_center_x) + 17'(right_center_x)) >> 1);
		midy_s1 <= 16'((17'(left_center_y) + 17'(right_center_y)) >> 1);
		la_s1   <= left_angle;
		ra_s1   <= right_angle;
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= 32'(dx_s1 * dx_s1);
		sqy_s2 <= 32'(dy_s1 * dy_s1);
		d2_s3  <= 33'(sqx_s2) + 33'(sqy_s2);
	end

	// floor(256 * sqrt(d2)) = isqrt(d2 << 16)
	lpg_isqrt u_isqrt (
		.clk      (clk),
		.radicand ({1'b0, d2_s3, 16'b0}),
		.root     (root_s28)
	);

	lpg_delay #(.W(16), .DEPTH(27)) u_dly_maxl (
		.clk (clk), .din (maxl_s1), .dout (maxl_s28)
	);

	// quotient tops out when root / maxl >= 2^16
	always_ff @(posedge clk) begin
		root_s29 <= root_s28;
		maxl_s29 <= maxl_s28;
		ssat_s29 <= 16'(root_s28[24:16]) >= maxl_s28;
		snz_s29  <= maxl_s28 != '0;
	end

	lpg_div #(.NW(25)) u_div_span (
		.clk      (clk),
		.dividend (root_s29),
		.divisor  (maxl_s29),
		.quotient (span_q45)
	);

	lpg_delay #(.W(2), .DEPTH(16)) u_dly_sflags (
		.clk (clk), .din ({snz_s29, ssat_s29}), .dout (sflags_s45)
	);

	// length ratio: (maxl << 8) / minl, tops out when maxl >= 256 * minl
	assign lsat_s1 = 16'(maxl_s1[15:8]) >= minl_s1;
	assign lnz_s1  = minl_s1 != '0;

	lpg_div #(.NW(24)) u_div_len (
		.clk      (clk),
		.dividend ({maxl_s1, 8'b0}),
		.divisor  (minl_s1),
		.quotient (len_q17)
	);

	lpg_delay #(.W(16), .DEPTH(28)) u_dly_lenq (
		.clk (clk), .din (len_q17), .dout (len_q45)
	);

	lpg_delay #(.W(2), .DEPTH(44)) u_dly_lflags (
		.clk (clk), .din ({lnz_s1, lsat_s1}), .dout (lflags_s45)
	);

	lpg_delay #(.W(32), .DEPTH(44)) u_dly_mid (
		.clk (clk), .din ({midx_s1, midy_s1}), .dout (mid_s45)
	);

	// centre line angle, then per-bar error against it
	lpg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk  (clk),
		.dx   (dx_s1),
		.dy   (dy_s1),
		.roll (roll_c)
	);

	lpg_delay #(.W(2*ANG_W), .DEPTH(CORDIC_STAGES + 2)) u_dly_ang (
		.clk (clk), .din ({la_s1, ra_s1}), .dout (ang_al)
	);

	lpg_err u_err (
		.clk         (clk),
		.left_angle  (ang_al[2*ANG_W-1:ANG_W]),
		.right_angle (ang_al[ANG_W-1:0]),
		.roll        (roll_c),
		.err         (err_c)
	);

	lpg_delay #(.W(ERR_W), .DEPTH(40 - CORDIC_STAGES)) u_dly_err (
		.clk (clk), .din (err_c), .dout (err_s45)
	);

	// output register: saturation and divide-by-zero handling
	always_ff @(posedge clk) begin
		mid_x              <= mid_s45[31:16];
		mid_y              <= mid_s45[15:0];
		span_ratio_valid   <= sflags_s45[1];
		length_ratio_valid <= lflags_s45[1];
		squareness_error   <= err_s45;
		if (!sflags_s45[1]) begin
			span_ratio <= '0;
		end else if (sflags_s45[0]) begin
			span_ratio <= SAT16;
		end else begin
			span_ratio <= span_q45;
		end
		if (!lflags_s45[1]) begin
			length_ratio <= '0;
		end else if (lflags_s45[0]) begin
			length_ratio <= SAT16;
		end else begin
			length_ratio <= len_q45;
		end
	end
endmodule
`default_nettype wire

### verif/lightbar_pair_geometry_unit_tb.sv
// lightbar_pair_geometry_unit_tb: self-checking bench for the light-bar pair geometry unit
// holds a bit-exact predictor of midpoint, ratios and squareness error plus a result scoreboard
// depends on lpg_pkg and the lightbar_pair_geometry_unit rtl
`timescale 1ns / 100ps
`default_nettype none

module lightbar_pair_geometry_unit_tb;
	import lpg_pkg::*;

	localparam int LATENCY   = 46;
	localparam int WDOG_MAX  = 2000;
	localparam int N_RANDOM  = 500;

	typedef struct packed {
		logic [15:0] lx, ly, ll;
		logic signed [15:0] la;
		logic [15:0] rx, ry, rl;
		logic signed [15:0] ra;
	} bar_pair_t;

	typedef struct packed {
		logic [15:0] mid_x, mid_y, span_ratio;
		logic        span_valid;
		logic [15:0] length_ratio;
		logic        length_valid;
		logic [13:0] sq_err;
	} pair_geom_t;

	// exact integer square root of a 64-bit value
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned rem, res, bitv;
		rem = n;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// centre-line direction in Q3.13 via vectoring cordic
	function automatic longint centre_line_angle(input longint dx, input longint dy);
		longint x, y, z, xs, ys;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(Z_PI) : -longint'(Z_PI);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(cordic_atan(i));
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(cordic_atan(i));
			end
		end
		return (z + 65536) >>> 17;
	endfunction

	function automatic longint perp_error(input longint angle, input longint roll);
		longint r, pi_q;
		pi_q = longint'(ANG_PI);
		r = (angle - roll - longint'(ANG_HALF_PI)) % pi_q;
		if (r < 0) r = r + pi_q;
		return (r <= pi_q - r) ? r : pi_q - r;
	endfunction

	function automatic pair_geom_t predict_geometry(input bar_pair_t p);
		pair_geom_t g;
		longint dx, dy, roll, el, er;
		longint unsigned maxl, minl, d2, q;
		dx = longint'(p.rx) - longint'(p.lx);
		dy = longint'(p.ry) - longint'(p.ly);
		maxl = (p.ll > p.rl) ? 64'(p.ll) : 64'(p.rl);
		minl = (p.ll < p.rl) ? 64'(p.ll) : 64'(p.rl);
		g.mid_x = 16'((17'(p.lx) + 17'(p.rx)) >> 1);
		g.mid_y = 16'((17'(p.ly) + 17'(p.ry)) >> 1);
		d2 = longint'(dx * dx) + longint'(dy * dy);
		g.span_ratio = '0;
		g.span_valid = (maxl != 0);
		if (maxl != 0) begin
			q = int_sqrt(d2 << 16) / maxl;
			g.span_ratio = (q > 65535) ? SAT16 : q[15:0];
		end
		g.length_ratio = '0;
		g.length_valid = (minl != 0);
		if (minl != 0) begin
			q = (maxl << 8) / minl;
			g.length_ratio = (q > 65535) ? SAT16 : q[15:0];
		end
		roll = centre_line_angle(dx, dy);
		el = perp_error(longint'(p.la), roll);
		er = perp_error(longint'(p.ra), roll);
		g.sq_err = (el > er) ? el[13:0] : er[13:0];
		return g;
	endfunction

	class geom_scoreboard;
		pair_geom_t pending[$];
		int errors;
		int checked;

		function new();
			errors = 0;
			checked = 0;
		endfunction

		function void note_pair(input bar_pair_t p);
			pending.push_back(predict_geometry(p));
		endfunction

		function void check_result(input pair_geom_t got);
			pair_geom_t want;
			if (pending.size() == 0) begin
				$error("result with no pair outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.mid_x !== want.mid_x) begin
				$error("mid_x expected %0d actual %0d", want.mid_x, got.mid_x);
				errors++;
			end
			if (got.mid_y !== want.mid_y) begin
				$error("mid_y expected %0d actual %0d", want.mid_y, got.mid_y);
				errors++;
			end
			if (got.span_ratio !== want.span_ratio) begin
				$error("span_ratio expected %0d actual %0d", want.span_ratio, got.span_ratio);
				errors++;
			end
			if (got.span_valid !== want.span_valid) begin
				$error("span_ratio_valid expected %0d actual %0d", want.span_valid,
					got.span_valid);
				errors++;
			end
			if (got.length_ratio !== want.length_ratio) begin
				$error("length_ratio expected %0d actual %0d", want.length_ratio,
					got.length_ratio);
				errors++;
			end
			if (got.length_valid !== want.length_valid) begin
				$error("length_ratio_valid expected %0d actual %0d", want.length_valid,
					got.length_valid);
				errors++;
			end
			if (got.sq_err !== want.sq_err) begin
				$error("squareness_error expected %0d actual %0d", want.sq_err, got.sq_err);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	bar_pair_t drv;
	logic [15:0] mid_x, mid_y, span_ratio, length_ratio;
	logic span_ratio_valid, length_ratio_valid;
	logic [13:0] squareness_error;

	geom_scoreboard sb;
	int idle_cycles;
	int sent;
	int directed_cnt;
	bit quiet_stretch;

	lightbar_pair_geometry_unit uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.left_center_x      (drv.lx),
		.left_center_y      (drv.ly),
		.left_length        (drv.ll),
		.left_angle         (drv.la),
		.right_center_x     (drv.rx),
		.right_center_y     (drv.ry),
		.right_length       (drv.rl),
		.right_angle        (drv.ra),
		.done               (done),
		.mid_x              (mid_x),
		.mid_y              (mid_y),
		.span_ratio         (span_ratio),
		.span_ratio_valid   (span_ratio_valid),
		.length_ratio       (length_ratio),
		.length_ratio_valid (length_ratio_valid),
		.squareness_error   (squareness_error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// accepted items go to the scoreboard, strobed results get checked
	initial sb = new();
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_pair(drv);
		if (arst_n && done)
			sb.check_result({mid_x, mid_y, span_ratio, span_ratio_valid,
				length_ratio, length_ratio_valid, squareness_error});
	end

	// watchdog: cycles with nothing accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog expired with %0d results outstanding", sb.pending.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// offer one pair, with a random idle gap unless in the no-idle stretch
	task automatic send_pair(input bar_pair_t p);
		while (!quiet_stretch && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		drv <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic bar_pair_t random_pair();
		bar_pair_t p;
		int mode;
		p = bar_pair_t'({$urandom, $urandom, $urandom, $urandom});
		mode = $urandom_range(9);
		// mostly plausible bar pairs: near each other, similar lengths, modest tilts
		if (mode < 6) begin
			p.rx = p.lx + 16'($urandom_range(4000)) - 16'd2000;
			p.ry = p.ly + 16'($urandom_range(600)) - 16'd300;
			p.rl = 16'(p.ll[11:0]) + 16'($urandom_range(200));
			p.ll = 16'(p.ll[11:0]);
			p.la = 16'($urandom_range(4000)) - 16'sd2000;
			p.ra = 16'($urandom_range(4000)) - 16'sd2000;
		end else if (mode == 6) begin
			p.ll = 16'($urandom_range(3));
			p.rl = 16'($urandom_range(3));
		end else if (mode == 7) begin
			p.rx = p.lx;
			p.ry = p.ly;
		end
		return p;
	endfunction

	task automatic run_directed();
		bar_pair_t p;
		bar_pair_t dir[$];
		p = '0;
		dir.push_back(p);
		p = '1;
		dir.push_back(p);
		// zero lengths and saturating ratios
		p = '0; p.rx = 16'hFFFF; p.ry = 16'hFFFF; p.ll = 16'd1; p.rl = 16'hFFFF;
		dir.push_back(p);
		p = '0; p.rx = 16'hFFFF; p.ll = 16'd0; p.rl = 16'd0;
		dir.push_back(p);
		p = '0; p.ll = 16'd0; p.rl = 16'd100; p.rx = 16'd50;
		dir.push_back(p);
		// coincident centres
		p = '0; p.lx = 16'd1234; p.rx = 16'd1234; p.ly = 16'd77; p.ry = 16'd77;
		p.ll = 16'd300; p.rl = 16'd300; p.la = 16'sh7FFF; p.ra = -16'sh8000;
		dir.push_back(p);
		// line pointing left with dy positive, negative and zero, and vertical lines
		p = '0; p.lx = 16'd5000; p.rx = 16'd100; p.ly = 16'd100; p.ry = 16'd900;
		p.ll = 16'd400; p.rl = 16'd380; p.la = 16'sd1000; p.ra = -16'sd1000;
		dir.push_back(p);
		p.ry = 16'd0;
		dir.push_back(p);
		p.ry = p.ly;
		dir.push_back(p);
		p = '0; p.ly = 16'd10; p.ry = 16'hFFF0; p.ll = 16'd500; p.rl = 16'd500;
		dir.push_back(p);
		p.ly = 16'hFFF0; p.ry = 16'd10;
		dir.push_back(p);
		// perpendicular bars, angle extremes
		p = '0; p.rx = 16'd1600; p.ll = 16'd320; p.rl = 16'd320;
		dir.push_back(p);
		p.la = 16'sh7FFF; p.ra = -16'sh8000;
		dir.push_back(p);
		p.la = 16'sd12868; p.ra = -16'sd12868;
		dir.push_back(p);
		p.la = 16'sd25736; p.ra = 16'sd6434;
		dir.push_back(p);
		foreach (dir[i]) send_pair(dir[i]);
		directed_cnt = dir.size();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		drv = '0;
		sent = 0;
		quiet_stretch = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		// sender holds off until the pipeline has fully drained
		wait_drained();
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet_stretch = (n >= 200 && n < 300);
			send_pair(random_pair());
		end
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d bar pairs (%0d directed), checked %0d results", sent,
			directed_cnt, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire

### lightbar_pair_geometry_unit.f
rtl/lpg_pkg.sv
rtl/lpg_delay.sv
rtl/lpg_isqrt.sv
rtl/lpg_div.sv
rtl/lpg_cordic.sv
rtl/lpg_err.sv
rtl/lightbar_pair_geometry_unit.sv
verif/lightbar_pair_geometry_unit_tb.sv
